// ===== design/gbfp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gbfp_pkg
// Types, constants and codes shared by the binary frame parser modules.
// ----------------------------------------------------------------------------
package gbfp_pkg;

	localparam int unsigned HEADER_BYTES_DEF = 24;
	localparam int unsigned HDR_CNT_W        = 5;
	localparam int unsigned LEN_W            = 16;
	localparam int unsigned ID_W             = 16;
	localparam int unsigned CRC_W            = 32;

	localparam logic [7:0] SYNC_A = 8'hAA;
	localparam logic [7:0] SYNC_B = 8'h44;
	localparam logic [7:0] SYNC_C = 8'hB5;

	localparam logic [CRC_W-1:0] CRC_POLY = 32'hEDB88320;

	localparam logic [HDR_CNT_W-1:0] CNT_SYNC1  = 5'd1;
	localparam logic [HDR_CNT_W-1:0] CNT_SYNC2  = 5'd2;
	localparam logic [HDR_CNT_W-1:0] CNT_SYNC3  = 5'd3;
	localparam logic [HDR_CNT_W-1:0] OFS_ID_LO  = 5'd4;
	localparam logic [HDR_CNT_W-1:0] OFS_ID_HI  = 5'd5;
	localparam logic [HDR_CNT_W-1:0] OFS_LEN_LO = 5'd6;
	localparam logic [HDR_CNT_W-1:0] OFS_LEN_HI = 5'd7;

	localparam logic [LEN_W-1:0] CRC_BYTES = 16'd4;

	typedef enum logic [2:0] {
		PH_HUNT   = 3'd0,
		PH_SYNC2  = 3'd1,
		PH_SYNC3  = 3'd2,
		PH_HEADER = 3'd3,
		PH_DATA   = 3'd4,
		PH_CRC    = 3'd5
	} phase_t;

	typedef enum logic [1:0] {
		ST_IDLE = 2'd0,
		ST_IN   = 2'd1,
		ST_GOOD = 2'd2,
		ST_BAD  = 2'd3
	} status_t;

	typedef struct packed {
		status_t           status;
		logic [ID_W-1:0]   message_id;
		logic [LEN_W-1:0]  payload_length;
	} gbfp_result_t;

endpackage : gbfp_pkg
`default_nettype wire

// ===== design/gbfp_crc_byte.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gbfp_crc_byte
// Advances a reflected CRC-32 by one byte, eight bit steps in combinational logic.
// ----------------------------------------------------------------------------
module gbfp_crc_byte (
	input  wire logic [gbfp_pkg::CRC_W-1:0] crc_in,
	input  wire logic [7:0]                 data,
	output logic      [gbfp_pkg::CRC_W-1:0] crc_out
);
	import gbfp_pkg::*;

	always_comb begin
		logic [CRC_W-1:0] c;
		c = crc_in ^ {{(CRC_W-8){1'b0}}, data};
		for (int i = 0; i < 8; i++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		crc_out = c;
	end

endmodule : gbfp_crc_byte
`default_nettype wire

// ===== design/gbfp_frame_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gbfp_frame_core
// Frame state, header capture and CRC accumulation, one byte per step.
// ----------------------------------------------------------------------------
module gbfp_frame_core #(
	parameter int unsigned HEADER_BYTES = gbfp_pkg::HEADER_BYTES_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   step,
	input  wire logic [7:0]             rx_byte,
	output gbfp_pkg::gbfp_result_t      result
);
	import gbfp_pkg::*;

	phase_t                phase_q, phase_d;
	logic [CRC_W-1:0]      crc_q, crc_d, crc_seed, crc_new;
	logic [HDR_CNT_W-1:0]  cnt_q, cnt_d, cnt_inc;
	logic [LEN_W-1:0]      left_q, left_d, left_dec;
	logic [ID_W-1:0]       id_q, id_d;
	logic [LEN_W-1:0]      len_q, len_d;
	logic                  hunt_sel;
	status_t               status;

	always_comb begin
		case (phase_q)
			PH_SYNC2:  hunt_sel = (rx_byte != SYNC_B);
			PH_SYNC3:  hunt_sel = (rx_byte != SYNC_C);
			PH_HEADER: hunt_sel = 1'b0;
			PH_DATA:   hunt_sel = 1'b0;
			PH_CRC:    hunt_sel = 1'b0;
			default:   hunt_sel = 1'b1;
		endcase
	end

	assign crc_seed = hunt_sel ? '0 : crc_q;
	assign cnt_inc  = cnt_q + 1'b1;
	assign left_dec = left_q - 1'b1;

	gbfp_crc_byte u_crc (
		.crc_in  (crc_seed),
		.data    (rx_byte),
		.crc_out (crc_new)
	);

	always_comb begin
		phase_d = phase_q;
		crc_d   = crc_q;
		cnt_d   = cnt_q;
		left_d  = left_q;
		id_d    = id_q;
		len_d   = len_q;
		status  = ST_IN;
		if (hunt_sel) begin
			if (rx_byte != SYNC_A) begin
				phase_d = PH_HUNT;
				status  = ST_IDLE;
			end else begin
				crc_d   = crc_new;
				cnt_d   = CNT_SYNC1;
				left_d  = '0;
				id_d    = '0;
				len_d   = '0;
				phase_d = PH_SYNC2;
			end
		end else begin
			crc_d = crc_new;
			case (phase_q)
				PH_SYNC2: begin
					cnt_d   = CNT_SYNC2;
					phase_d = PH_SYNC3;
				end
				PH_SYNC3: begin
					cnt_d   = CNT_SYNC3;
					phase_d = PH_HEADER;
				end
				PH_HEADER: begin
					case (cnt_q)
						OFS_ID_LO:  id_d  = {id_q[ID_W-1:8], rx_byte};
						OFS_ID_HI:  id_d  = {rx_byte, id_q[7:0]};
						OFS_LEN_LO: len_d = {len_q[LEN_W-1:8], rx_byte};
						OFS_LEN_HI: len_d = {rx_byte, len_q[7:0]};
						default: ;
					endcase
					cnt_d = cnt_inc;
					if (cnt_inc >= HDR_CNT_W'(HEADER_BYTES)) begin
						if (len_d == '0) begin
							left_d  = CRC_BYTES;
							phase_d = PH_CRC;
						end else begin
							left_d  = len_d;
							phase_d = PH_DATA;
						end
					end
				end
				PH_DATA: begin
					if (left_dec == '0) begin
						left_d  = CRC_BYTES;
						phase_d = PH_CRC;
					end else begin
						left_d = left_dec;
					end
				end
				PH_CRC: begin
					left_d = left_dec;
					if (left_dec == '0) begin
						status  = (crc_new == '0) ? ST_GOOD : ST_BAD;
						phase_d = PH_HUNT;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT;
			crc_q   <= '0;
			cnt_q   <= '0;
			left_q  <= '0;
			id_q    <= '0;
			len_q   <= '0;
		end else if (step) begin
			phase_q <= phase_d;
			crc_q   <= crc_d;
			cnt_q   <= cnt_d;
			left_q  <= left_d;
			id_q    <= id_d;
			len_q   <= len_d;
		end
	end

	assign result.status         = status;
	assign result.message_id     = id_d;
	assign result.payload_length = len_d;

endmodule : gbfp_frame_core
`default_nettype wire

// ===== design/gnss_binary_frame_parser_unit.sv =====
// An accepted word waits in the input register and steps the frame core into the output
// register, one word per cycle while out_ready does not stall the output. The input and
// output registers are parted so a new word is taken while a finished result still waits.
// Reset is asynchronous and active low; it returns the parser to hunting for the first
// sync byte with the CRC, counters and captures cleared.
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gnss_binary_frame_parser_unit
// Byte stream deframer for sync-led binary frames with a CRC-32 check.
// ----------------------------------------------------------------------------
module gnss_binary_frame_parser_unit #(
	parameter int unsigned HEADER_BYTES = gbfp_pkg::HEADER_BYTES_DEF
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       in_valid,
	output logic                            in_ready,
	input  wire logic [7:0]                 rx_byte,
	output logic                            out_valid,
	input  wire logic                       out_ready,
	output logic [7:0]                      echo_byte,
	output logic [1:0]                      frame_status,
	output logic [gbfp_pkg::ID_W-1:0]       message_id,
	output logic [gbfp_pkg::LEN_W-1:0]      payload_length
);
	import gbfp_pkg::*;

	logic          valid_s1;
	logic [7:0]    byte_s1;
	logic          advance;
	logic          out_valid_q;
	logic [7:0]    echo_q;
	gbfp_result_t  core_res;
	gbfp_result_t  res_q;

	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= rx_byte;
		end
	end

	gbfp_frame_core #(
		.HEADER_BYTES (HEADER_BYTES)
	) u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (advance),
		.rx_byte (byte_s1),
		.result  (core_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			echo_q <= byte_s1;
			res_q  <= core_res;
		end
	end

	assign out_valid      = out_valid_q;
	assign echo_byte      = echo_q;
	assign frame_status   = res_q.status;
	assign message_id     = res_q.message_id;
	assign payload_length = res_q.payload_length;

endmodule : gnss_binary_frame_parser_unit
`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives a byte stream into the frame parser and checks every output word against
// an in-bench deframer with its own CRC-32 or a typed table, covering sync slips,
// zero-length and long frames, and good and corrupted checksums.
// ----------------------------------------------------------------------------
module testbench;

	import gbfp_pkg::*;

	localparam int unsigned HDR_LEN   = HEADER_BYTES_DEF;
	localparam int          STALL_CAP = 1000;
	localparam int          PHASE_LEN = 120;

	typedef struct packed {
		logic [7:0]       echo;
		status_t          status;
		logic [ID_W-1:0]  id;
		logic [LEN_W-1:0] len;
	} parse_result_t;

	typedef struct packed {
		logic [7:0] b;
		status_t    st;
	} sync_row_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_ready;
	logic [7:0]        rx_byte = 8'h00;
	logic              out_valid;
	logic              out_ready = 1'b0;
	logic [7:0]        echo_byte;
	logic [1:0]        frame_status;
	logic [ID_W-1:0]   message_id;
	logic [LEN_W-1:0]  payload_length;

	phase_t                ps_phase = PH_HUNT;
	logic [CRC_W-1:0]      ps_crc = '0;
	logic [HDR_CNT_W-1:0]  ps_hdr = '0;
	logic [LEN_W-1:0]      ps_left = '0;
	logic [ID_W-1:0]       ps_id = '0;
	logic [LEN_W-1:0]      ps_len = '0;

	parse_result_t parsed_q [$];
	int            mismatch_count = 0;
	int            words_sent = 0;
	int            quiet_cycles = 0;
	int            send_idle_pct = 0;
	int            stall_pct = 0;

	sync_row_t sync_rows [20] = '{
		'{8'h00, ST_IDLE}, '{8'hFF, ST_IDLE}, '{8'h80, ST_IDLE}, '{8'h7F, ST_IDLE},
		'{SYNC_B, ST_IDLE}, '{SYNC_C, ST_IDLE},
		'{SYNC_A, ST_IN}, '{8'h00, ST_IDLE},
		'{SYNC_A, ST_IN}, '{SYNC_B, ST_IN}, '{8'h00, ST_IDLE},
		'{SYNC_A, ST_IN}, '{SYNC_A, ST_IN}, '{SYNC_B, ST_IN}, '{SYNC_A, ST_IN},
		'{SYNC_B, ST_IN}, '{SYNC_B, ST_IDLE},
		'{SYNC_A, ST_IN}, '{SYNC_B, ST_IN}, '{8'hFF, ST_IDLE}
	};

	gnss_binary_frame_parser_unit u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.rx_byte        (rx_byte),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.echo_byte      (echo_byte),
		.frame_status   (frame_status),
		.message_id     (message_id),
		.payload_length (payload_length)
	);

	always #5 clk = ~clk;

	function automatic logic [CRC_W-1:0] crc8(input logic [CRC_W-1:0] c, input logic [7:0] b);
		logic [CRC_W-1:0] r;
		r = c ^ {24'h0, b};
		for (int i = 0; i < 8; i++) begin
			r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
		end
		return r;
	endfunction

	function automatic status_t resync(input logic [7:0] b);
		if (b != SYNC_A) begin
			ps_phase = PH_HUNT;
			return ST_IDLE;
		end
		ps_crc = crc8('0, b);
		ps_hdr = CNT_SYNC1;
		ps_left = '0;
		ps_id = '0;
		ps_len = '0;
		ps_phase = PH_SYNC2;
		return ST_IN;
	endfunction

	function automatic parse_result_t deframe_byte(input logic [7:0] b);
		parse_result_t r;
		status_t st;
		st = ST_IN;
		case (ps_phase)
		PH_SYNC2: begin
			if (b != SYNC_B) begin
				st = resync(b);
			end else begin
				ps_crc = crc8(ps_crc, b);
				ps_hdr = CNT_SYNC2;
				ps_phase = PH_SYNC3;
			end
		end
		PH_SYNC3: begin
			if (b != SYNC_C) begin
				st = resync(b);
			end else begin
				ps_crc = crc8(ps_crc, b);
				ps_hdr = CNT_SYNC3;
				ps_phase = PH_HEADER;
			end
		end
		PH_HEADER: begin
			ps_crc = crc8(ps_crc, b);
			case (ps_hdr)
			OFS_ID_LO:  ps_id[7:0] = b;
			OFS_ID_HI:  ps_id[15:8] = b;
			OFS_LEN_LO: ps_len[7:0] = b;
			OFS_LEN_HI: ps_len[15:8] = b;
			default: ;
			endcase
			ps_hdr = ps_hdr + 1'b1;
			if (int'(ps_hdr) >= HDR_LEN) begin
				if (ps_len == '0) begin
					ps_left = CRC_BYTES;
					ps_phase = PH_CRC;
				end else begin
					ps_left = ps_len;
					ps_phase = PH_DATA;
				end
			end
		end
		PH_DATA: begin
			ps_crc = crc8(ps_crc, b);
			ps_left = ps_left - 1'b1;
			if (ps_left == '0) begin
				ps_left = CRC_BYTES;
				ps_phase = PH_CRC;
			end
		end
		PH_CRC: begin
			ps_crc = crc8(ps_crc, b);
			ps_left = ps_left - 1'b1;
			if (ps_left == '0) begin
				st = (ps_crc == '0) ? ST_GOOD : ST_BAD;
				ps_phase = PH_HUNT;
			end
		end
		default: begin
			st = resync(b);
		end
		endcase
		r.echo = b;
		r.status = st;
		r.id = ps_id;
		r.len = ps_len;
		return r;
	endfunction

	task automatic flag_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("%0t mismatch on %s: got %0h, want %0h", $time, what, got, want);
		mismatch_count++;
	endtask

	task automatic send_word(input logic [7:0] b, input bit typed = 1'b0,
			input parse_result_t typed_res = '0);
		parse_result_t res;
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		rx_byte <= b;
		@(posedge clk);
		while (!in_ready) begin
			@(posedge clk);
		end
		res = deframe_byte(b);
		if (typed) begin
			res = typed_res;
		end
		parsed_q.push_back(res);
		words_sent++;
	endtask

	task automatic send_frame(input logic [15:0] id, input logic [15:0] len, input bit spoil);
		logic [7:0] fb [$];
		logic [CRC_W-1:0] c;
		int at;
		fb.push_back(SYNC_A);
		fb.push_back(SYNC_B);
		fb.push_back(SYNC_C);
		fb.push_back(8'($urandom));
		fb.push_back(id[7:0]);
		fb.push_back(id[15:8]);
		fb.push_back(len[7:0]);
		fb.push_back(len[15:8]);
		while (fb.size() < HDR_LEN) begin
			fb.push_back(8'($urandom));
		end
		for (int k = 0; k < int'(len); k++) begin
			fb.push_back(8'($urandom));
		end
		c = '0;
		foreach (fb[k]) begin
			c = crc8(c, fb[k]);
		end
		fb.push_back(c[7:0]);
		fb.push_back(c[15:8]);
		fb.push_back(c[23:16]);
		fb.push_back(c[31:24]);
		if (spoil) begin
			at = $urandom_range(fb.size() - 1, 8);
			fb[at] = fb[at] ^ 8'($urandom_range(255, 1));
		end
		foreach (fb[k]) begin
			send_word(fb[k]);
		end
	endtask

	function automatic logic [15:0] pick_length();
		int r;
		r = $urandom_range(99);
		if (r < 35) begin
			return 16'd0;
		end else if (r < 85) begin
			return 16'($urandom_range(12, 1));
		end
		return 16'($urandom_range(80, 13));
	endfunction

	task automatic send_line_noise();
		logic [7:0] b;
		int r;
		r = $urandom_range(99);
		if (r < 20) begin
			repeat ($urandom_range(6, 1)) begin
				do b = 8'($urandom); while (b == SYNC_A);
				send_word(b);
			end
		end else if (r < 30) begin
			send_word(SYNC_A);
			do b = 8'($urandom); while (b == SYNC_B);
			send_word(b);
		end else if (r < 40) begin
			send_word(SYNC_A);
			send_word(SYNC_B);
			do b = 8'($urandom); while (b == SYNC_C);
			send_word(b);
		end
	endtask

	task automatic set_idling(input int mode);
		case (mode)
		0: begin send_idle_pct = 0;  stall_pct = 0;  end
		1: begin send_idle_pct = 46; stall_pct = 0;  end
		2: begin send_idle_pct = 0;  stall_pct = 46; end
		default: begin send_idle_pct = 10; stall_pct = 10; end
		endcase
	endtask

	task automatic hold_until_drained();
		in_valid <= 1'b0;
		while (parsed_q.size() != 0) begin
			@(posedge clk);
		end
	endtask

	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= stall_pct);
	end

	always @(posedge clk) begin : check_words
		parse_result_t want;
		if (out_valid && out_ready) begin
			if (parsed_q.size() == 0) begin
				flag_mismatch("word with nothing awaited", 32'(echo_byte), '0);
			end else begin
				want = parsed_q.pop_front();
				if (echo_byte !== want.echo)
					flag_mismatch("echo_byte", 32'(echo_byte), 32'(want.echo));
				if (frame_status !== want.status)
					flag_mismatch("frame_status", 32'(frame_status), 32'(want.status));
				if (message_id !== want.id)
					flag_mismatch("message_id", 32'(message_id), 32'(want.id));
				if (payload_length !== want.len)
					flag_mismatch("payload_length", 32'(payload_length), 32'(want.len));
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_CAP) begin
			$display("testbench: errors");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin : stimulus
		parse_result_t typed_res;
		int target;
		set_idling(0);
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (sync_rows[i]) begin
			typed_res = '{echo: sync_rows[i].b, status: sync_rows[i].st, id: '0, len: '0};
			send_word(sync_rows[i].b, 1'b1, typed_res);
		end
		send_frame(16'hFFFF, 16'd0, 1'b0);
		send_frame(16'h0000, 16'd0, 1'b1);
		send_frame(16'h0000, 16'd1, 1'b0);
		send_frame(16'($urandom), 16'h0100, 1'b0);

		for (int mode = 0; mode < 4; mode++) begin
			set_idling(mode);
			target = words_sent + PHASE_LEN;
			while (words_sent < target) begin
				send_line_noise();
				send_frame(16'($urandom), pick_length(), $urandom_range(99) < 25);
			end
			// The sender holds off here until every word in flight has come back.
			hold_until_drained();
		end

		hold_until_drained();
		repeat (4) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("testbench: clean");
		end else begin
			$display("testbench: errors");
		end
		$finish;
	end

endmodule
